// ===== rtl/core/crrd_pkg.sv =====
`default_nettype none
package crrd_pkg;

  localparam int MAX_DIM_DEFAULT = 2048;

  localparam int PIX_W       = 8;
  localparam int DIM_CFG_W   = 12;
  localparam int MARGIN_W    = 8;
  localparam int TARGET_W    = 2;
  localparam int NREG_W      = 2;
  localparam int COUNT_W     = 22;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [DIM_CFG_W-1:0] WIDTH_RST     = 12'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST    = 12'd480;
  localparam logic [MARGIN_W-1:0]  HMARGIN_RST   = 8'd32;
  localparam logic [MARGIN_W-1:0]  VMARGIN_RST   = 8'd32;
  localparam logic [PIX_W-1:0]     THRESHOLD_RST = 8'd60;
  localparam logic [TARGET_W-1:0]  TARGET_RST    = 2'd1;
  localparam logic [MARGIN_W-1:0]  FRACTION_RST  = 8'd64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_IMAGE_HEIGHT   = 3'd1,
    CFG_HORIZ_MARGIN   = 3'd2,
    CFG_VERT_MARGIN    = 3'd3,
    CFG_BASE_THRESHOLD = 3'd4,
    CFG_TARGET_REGIONS = 3'd5,
    CFG_RED_FRACTION   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_COUNT = 2'd1,
    ST_MUL   = 2'd2,
    ST_JUDGE = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_RED   = 2'd1,
    CLS_GREEN = 2'd2,
    CLS_BLUE  = 2'd3
  } pix_class_t;

  typedef struct packed {
    logic load;
    logic count;
    logic mul;
    logic judge;
  } dp_cmd_t;

  typedef struct packed {
    logic eof;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/crrd_ctrl.sv =====
`default_nettype none
module crrd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire crrd_pkg::dp_status_t status,
  output crrd_pkg::dp_cmd_t        cmd
);
  import crrd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_COUNT;
      ST_COUNT: state_nxt = status.eof ? ST_MUL : ST_IDLE;
      ST_MUL:   state_nxt = ST_JUDGE;
      ST_JUDGE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_COUNT: cmd.count = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_JUDGE: begin
        cmd.judge = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/crrd_dp.sv =====
`default_nettype none
module crrd_dp #(
  parameter int MAX_DIM = crrd_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [crrd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [crrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [crrd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                                in_tlast,
  output logic [crrd_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire crrd_pkg::dp_cmd_t                   cmd,
  output crrd_pkg::dp_status_t                     status
);
  import crrd_pkg::*;

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int CW   = $clog2(MAX_DIM);
  localparam int EW   = (DIM_CFG_W > DW) ? DIM_CFG_W : DW;
  localparam int PW   = MARGIN_W + DW;
  localparam int AW   = 2 * CW;
  localparam int FW   = AW + MARGIN_W;
  localparam int RW   = COUNT_W + 8;
  localparam int CMPW = (RW > FW) ? RW : FW;

  // configuration registers
  logic [DIM_CFG_W-1:0] width_r, height_r;
  logic [MARGIN_W-1:0]  hmargin_r, vmargin_r, fraction_r;
  logic [PIX_W-1:0]     threshold_r;
  logic [TARGET_W-1:0]  target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      hmargin_r   <= HMARGIN_RST;
      vmargin_r   <= VMARGIN_RST;
      threshold_r <= THRESHOLD_RST;
      target_r    <= TARGET_RST;
      fraction_r  <= FRACTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:    width_r     <= cfg_wdata;
        CFG_IMAGE_HEIGHT:   height_r    <= cfg_wdata;
        CFG_HORIZ_MARGIN:   hmargin_r   <= cfg_wdata[MARGIN_W-1:0];
        CFG_VERT_MARGIN:    vmargin_r   <= cfg_wdata[MARGIN_W-1:0];
        CFG_BASE_THRESHOLD: threshold_r <= cfg_wdata[PIX_W-1:0];
        CFG_TARGET_REGIONS: target_r    <= cfg_wdata[TARGET_W-1:0];
        CFG_RED_FRACTION:   fraction_r  <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame geometry, registered off the config
  logic [DW-1:0] w_cl, h_cl;
  logic [EW-1:0] wx, hx;
  logic [PW-1:0] rw_prod, rh_prod;
  logic [DW-1:0] w_r, h_r;
  logic [CW-1:0] rw_r, rh_r;
  logic [AW-1:0] area_r;
  logic [FW-1:0] frac_prod_r;

  always_comb begin
    wx = EW'(width_r);
    hx = EW'(height_r);
    priority if (wx == '0) w_cl = DW'(1);
    else if (wx > EW'(MAX_DIM)) w_cl = DW'(MAX_DIM);
    else w_cl = DW'(wx);
    priority if (hx == '0) h_cl = DW'(1);
    else if (hx > EW'(MAX_DIM)) h_cl = DW'(MAX_DIM);
    else h_cl = DW'(hx);
  end

  assign rw_prod = PW'(hmargin_r) * PW'(w_cl);
  assign rh_prod = PW'(vmargin_r) * PW'(h_cl);

  always_ff @(posedge clk) begin
    w_r    <= w_cl;
    h_r    <= h_cl;
    rw_r   <= rw_prod[MARGIN_W +: CW];
    rh_r   <= rh_prod[MARGIN_W +: CW];
    area_r <= AW'(rw_r) * AW'(rh_r);
    if (cmd.mul) frac_prod_r <= FW'(fraction_r) * FW'(area_r);
  end

  // pixel holding register
  logic [PIX_W-1:0] pb_r, pg_r, pr_r;
  logic             eof_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pb_r  <= in_tdata[0 +: PIX_W];
      pg_r  <= in_tdata[PIX_W +: PIX_W];
      pr_r  <= in_tdata[2*PIX_W +: PIX_W];
      eof_r <= in_tlast;
    end
  end

  assign status.eof = eof_r;

  // classify and locate
  pix_class_t    cls;
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [CW:0]   col_inc, row_inc;
  logic [DW-1:0] w_lo, h_lo;
  logic [1:0]    in_region;

  always_comb begin
    cls = CLS_NONE;
    priority if (pr_r >= pg_r && pr_r >= pb_r) begin
      if (pr_r > threshold_r) cls = CLS_RED;
    end else if (pg_r >= pb_r) begin
      if (pg_r > threshold_r) cls = CLS_GREEN;
    end else begin
      if (pb_r > threshold_r) cls = CLS_BLUE;
    end
  end

  assign w_lo = w_r - DW'(rw_r);
  assign h_lo = h_r - DW'(rh_r);

  assign in_region[0] = (col_r < rw_r) && (row_r < rh_r);
  assign in_region[1] = (DW'(col_r) >= w_lo) && (DW'(col_r) < w_r) &&
                        (DW'(row_r) >= h_lo) && (DW'(row_r) < h_r);

  assign col_inc = {1'b0, col_r} + (CW+1)'(1);
  assign row_inc = {1'b0, row_r} + (CW+1)'(1);

  always_comb begin
    col_nxt = col_inc[CW-1:0];
    row_nxt = row_r;
    if (col_inc >= (CW+1)'(w_r)) begin
      col_nxt = '0;
      row_nxt = (row_inc >= (CW+1)'(h_r)) ? '0 : row_inc[CW-1:0];
    end
  end

  // per-region counters, saturating
  logic [COUNT_W-1:0] red_cnt_r[2], green_cnt_r[2], blue_cnt_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.judge) begin
      col_r <= '0;
      row_r <= '0;
      for (int k = 0; k < 2; k++) begin
        red_cnt_r[k]   <= '0;
        green_cnt_r[k] <= '0;
        blue_cnt_r[k]  <= '0;
      end
    end else if (cmd.count) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      for (int k = 0; k < 2; k++) begin
        if (in_region[k]) begin
          unique case (cls)
            CLS_RED:
              if (red_cnt_r[k] != COUNT_MAX) red_cnt_r[k] <= red_cnt_r[k] + 1'b1;
            CLS_GREEN:
              if (green_cnt_r[k] != COUNT_MAX) green_cnt_r[k] <= green_cnt_r[k] + 1'b1;
            CLS_BLUE:
              if (blue_cnt_r[k] != COUNT_MAX) blue_cnt_r[k] <= blue_cnt_r[k] + 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  // frame decision
  logic [1:0]        reg_red;
  logic [NREG_W-1:0] n_red;
  logic              is_red_r;
  logic [NREG_W-1:0] n_red_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      reg_red[k] = (red_cnt_r[k] > green_cnt_r[k]) && (red_cnt_r[k] > blue_cnt_r[k]) &&
                   (CMPW'({red_cnt_r[k], 8'd0}) > CMPW'(frac_prod_r));
    end
  end

  assign n_red = NREG_W'(reg_red[0]) + NREG_W'(reg_red[1]);

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      is_red_r <= (n_red >= NREG_W'(target_r));
      n_red_r  <= n_red;
    end
  end

  assign out_tdata = {{(OUT_TDATA_W-NREG_W-1){1'b0}}, n_red_r, is_red_r};

endmodule
`default_nettype wire

// ===== rtl/core/corner_region_red_dominance.sv =====
`default_nettype none
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     in_tdata: blue, green, red; in_tlast: end_of_frame
// out_     out  out_tvalid / out_tready   out_tdata: is_red_card, red_region_count
// cfg_     in   cfg_we                    cfg_addr, cfg_wdata
//
// a pixel beat is latched, then the per-region counters are updated; only then is the input ready again
// an end-of-frame beat goes through count, fraction multiply, then compare and load
// the output register holds the result, so the next frame starts while it waits
// a stalled result only holds the block once a second result is ready to load
// rst_n is synchronous: counters, position and config registers return to their defaults
module corner_region_red_dominance #(
  parameter int MAX_DIM = crrd_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [crrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [crrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [crrd_pkg::IN_TDATA_W-1:0] in_tdata,   // blue, green, red
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [crrd_pkg::OUT_TDATA_W-1:0]     out_tdata   // is_red_card, red_region_count, zero pad
);
  import crrd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  crrd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  crrd_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

// ===== rtl/core/crrd_chk.sv =====
`default_nettype none
module crrd_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            cfg_we,
  input wire logic [crrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input wire logic [crrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [crrd_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                            in_tlast,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [crrd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // at most two regions can be red
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:1] != 2'b11)
    else $error("red region count out of range");

  // ordinary pixel frees the input again once its count state is done
  a_pixel_turn: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> ##1 in_tready)
    else $error("pixel beat did not free the input");

  // end of frame keeps the input closed while the decision is made
  a_eof_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready ##1 !in_tready)
    else $error("input reopened during frame decision");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind corner_region_red_dominance crrd_chk u_crrd_chk (.*);
`default_nettype wire

// ===== bench/tb_corner_region_red_dominance.sv =====
`timescale 1ns / 100ps
module tb_corner_region_red_dominance;
  import crrd_pkg::*;

  localparam int DIM_LIMIT = MAX_DIM_DEFAULT;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    bit       eof;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } pixel_t;

  typedef struct packed {
    bit       is_red_card;
    bit [1:0] red_region_count;
  } verdict_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // blue, green, red
  logic                   in_tlast;   // end_of_frame
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // is_red_card, red_region_count, zero pad

  corner_region_red_dominance dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor copy of the registers and the frame state
  bit [11:0] width_cfg   = WIDTH_RST;
  bit [11:0] height_cfg  = HEIGHT_RST;
  bit [7:0]  hmargin_cfg = HMARGIN_RST;
  bit [7:0]  vmargin_cfg = VMARGIN_RST;
  bit [7:0]  thresh_cfg  = THRESHOLD_RST;
  bit [1:0]  target_cfg  = TARGET_RST;
  bit [7:0]  frac_cfg    = FRACTION_RST;

  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  bit [COUNT_W-1:0] red_n [2];
  bit [COUNT_W-1:0] green_n [2];
  bit [COUNT_W-1:0] blue_n [2];

  pixel_t   pixel_q [$];
  verdict_t verdict_q [$];
  pixel_t   offered;
  verdict_t due;
  bit       beat_taken = 1'b0;
  int       pix_queued = 0;
  int       pix_taken = 0;
  int       errors = 0;
  int       send_idle = 26;
  int       recv_idle = 53;
  int       hold_req = 0;
  int       hold_done = 0;
  int       hold_left = 0;
  int       idle_cycles = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned clamp_dim(bit [11:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return 32'(v);
  endfunction

  function automatic bit [COUNT_W-1:0] sat_inc(bit [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic bit region_red(int k, longint unsigned area);
    longint unsigned r;
    r = 64'(red_n[k]);
    if (!(r > green_n[k] && r > blue_n[k])) return 1'b0;
    return r * 256 > frac_cfg * area;
  endfunction

  task automatic absorb_pixel(pixel_t p);
    int unsigned w, h, rw, rh, n;
    longint unsigned area;
    pix_class_t cls;
    bit in_tl, in_br;
    verdict_t v;
    w = clamp_dim(width_cfg);
    h = clamp_dim(height_cfg);
    rw = (hmargin_cfg * w) >> 8;
    rh = (vmargin_cfg * h) >> 8;
    cls = CLS_NONE;
    if (p.red >= p.green && p.red >= p.blue) begin
      if (p.red > thresh_cfg) cls = CLS_RED;
    end else if (p.green >= p.blue) begin
      if (p.green > thresh_cfg) cls = CLS_GREEN;
    end else if (p.blue > thresh_cfg) begin
      cls = CLS_BLUE;
    end
    in_tl = col_pos < rw && row_pos < rh;
    in_br = col_pos >= w - rw && col_pos < w && row_pos >= h - rh && row_pos < h;
    for (int k = 0; k < 2; k++) begin
      if ((k == 0) ? in_tl : in_br) begin
        case (cls)
          CLS_RED:   red_n[k] = sat_inc(red_n[k]);
          CLS_GREEN: green_n[k] = sat_inc(green_n[k]);
          CLS_BLUE:  blue_n[k] = sat_inc(blue_n[k]);
          default: ;
        endcase
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (p.eof) begin
      area = 64'(rw);
      area = area * rh;
      n = 32'(region_red(0, area)) + 32'(region_red(1, area));
      v.is_red_card = (n >= target_cfg);
      v.red_region_count = n[1:0];
      verdict_q.push_back(v);
      col_pos = 0;
      row_pos = 0;
      for (int k = 0; k < 2; k++) begin
        red_n[k] = '0;
        green_n[k] = '0;
        blue_n[k] = '0;
      end
    end
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    p.eof = 1'b0;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        p.green = 8'($urandom_range(p.red));
        p.blue = 8'($urandom_range(p.red));
      end
      4, 5: begin
        p.red = 8'($urandom_range(p.green));
        p.blue = 8'($urandom_range(p.green));
      end
      6: begin
        p.red = 8'($urandom_range(p.blue));
        p.green = 8'($urandom_range(p.blue));
      end
      7: begin
        p.green = p.red;
        if ($urandom_range(1)) p.blue = p.red;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_pix(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit e);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.eof = e;
    pixel_q.push_back(p);
    pix_queued++;
  endtask

  // mostly whole frames, some cut short or run past the last row
  task automatic queue_frames(int n_items, int max_len, int tail);
    int unsigned len, full;
    int done;
    pixel_t p;
    full = clamp_dim(width_cfg) * clamp_dim(height_cfg);
    done = 0;
    while (done < n_items) begin
      if (full <= max_len && $urandom_range(9) < 7) len = full;
      else len = $urandom_range(max_len, 1);
      for (int i = 0; i < len; i++) begin
        p = rand_pixel();
        push_pix(p.red, p.green, p.blue, i == len - 1);
      end
      done += len;
    end
    for (int i = 0; i < tail; i++) begin
      p = rand_pixel();
      push_pix(p.red, p.green, p.blue, 1'b0);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_IMAGE_WIDTH:    width_cfg = val;
      CFG_IMAGE_HEIGHT:   height_cfg = val;
      CFG_HORIZ_MARGIN:   hmargin_cfg = val[7:0];
      CFG_VERT_MARGIN:    vmargin_cfg = val[7:0];
      CFG_BASE_THRESHOLD: thresh_cfg = val[7:0];
      CFG_TARGET_REGIONS: target_cfg = val[1:0];
      CFG_RED_FRACTION:   frac_cfg = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(bit [11:0] w, bit [11:0] h, bit [7:0] hm, bit [7:0] vm,
                         bit [7:0] thr, bit [1:0] tgt, bit [7:0] frac);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_HORIZ_MARGIN, 12'(hm));
    write_reg(CFG_VERT_MARGIN, 12'(vm));
    write_reg(CFG_BASE_THRESHOLD, 12'(thr));
    write_reg(CFG_TARGET_REGIONS, 12'(tgt));
    write_reg(CFG_RED_FRACTION, 12'(frac));
  endtask

  // wait for every beat and verdict, then let the pipeline empty
  task automatic settle();
    while (pix_taken != pix_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    beat_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      absorb_pixel(offered);
      pix_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (beat_taken || !in_tvalid)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        offered = pixel_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {offered.red, offered.green, offered.blue};
        in_tlast <= offered.eof;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no frame pending: tdata %h", out_tdata);
        errors++;
      end else begin
        due = verdict_q.pop_front();
        if (out_tdata[0] !== due.is_red_card) begin
          $error("is_red_card expected %0d got %0d", due.is_red_card, out_tdata[0]);
          errors++;
        end
        if (out_tdata[2:1] !== due.red_region_count) begin
          $error("red_region_count expected %0d got %0d", due.red_region_count,
                 out_tdata[2:1]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    for (int k = 0; k < 2; k++) begin
      red_n[k] = '0;
      green_n[k] = '0;
      blue_n[k] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, top-left corner: channel extremes, ties, threshold edge
    push_pix(8'd255, 8'd0, 8'd0, 1'b0);
    push_pix(8'd0, 8'd255, 8'd0, 1'b0);
    push_pix(8'd0, 8'd0, 8'd255, 1'b0);
    push_pix(8'd255, 8'd255, 8'd255, 1'b0);
    push_pix(8'd60, 8'd0, 8'd0, 1'b0);
    push_pix(8'd61, 8'd61, 8'd0, 1'b1);
    settle();

    // 4x4 frame with 2x2 corners, both corners red
    set_cfg(12'd4, 12'd4, 8'd128, 8'd128, 8'd0, 2'd2, 8'd0);
    push_pix(8'd255, 8'd0, 8'd0, 1'b0);
    push_pix(8'd1, 8'd0, 8'd0, 1'b0);
    push_pix(8'd0, 8'd0, 8'd0, 1'b0);
    push_pix(8'd255, 8'd255, 8'd255, 1'b0);
    push_pix(8'd200, 8'd200, 8'd0, 1'b0);
    push_pix(8'd0, 8'd0, 8'd0, 1'b0);
    push_pix(8'd0, 8'd255, 8'd0, 1'b0);
    push_pix(8'd0, 8'd0, 8'd255, 1'b0);
    push_pix(8'd7, 8'd9, 8'd9, 1'b0);
    push_pix(8'd255, 8'd0, 8'd255, 1'b0);
    push_pix(8'd0, 8'd255, 8'd255, 1'b0);
    push_pix(8'd0, 8'd0, 8'd255, 1'b0);
    push_pix(8'd128, 8'd0, 8'd128, 1'b0);
    push_pix(8'd0, 8'd128, 8'd0, 1'b0);
    push_pix(8'd255, 8'd254, 8'd254, 1'b0);
    push_pix(8'd128, 8'd128, 8'd128, 1'b1);
    settle();

    set_cfg(12'd8, 12'd6, 8'd128, 8'd128, 8'd60, 2'd1, 8'd64);
    queue_frames(200, 100, 0);
    settle();

    // zero size clamps to one pixel, corners empty
    set_cfg(12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 2'd0, 8'd255);
    queue_frames(40, 4, 0);
    settle();

    // oversize clamps to the maximum, only short frames
    set_cfg(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd0, 2'd2, 8'd0);
    queue_frames(80, 40, 0);
    settle();

    send_idle = 53;
    recv_idle = 26;
    set_cfg(12'd2, 12'd2, 8'd128, 8'd128, 8'd20, 2'd1, 8'd0);
    hold_req++;
    queue_frames(150, 4, 0);
    settle();

    // overlapping corners, ends part way through a frame
    set_cfg(12'd6, 12'd5, 8'd200, 8'd220, 8'd30, 2'd2, 8'd100);
    queue_frames(200, 60, 7);
    settle();

    send_idle = 0;
    recv_idle = 0;
    set_cfg(12'd9, 12'd3, 8'd100, 8'd255, 8'd10, 2'd3, 8'd30);
    queue_frames(150, 54, 0);
    settle();

    repeat (2) begin
      set_cfg(12'($urandom_range(12, 1)), 12'($urandom_range(10, 1)),
              8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(80)), 2'($urandom_range(2)),
              8'($urandom_range(255)));
      queue_frames(65, 150, 0);
      settle();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/crrd_pkg.sv
rtl/core/crrd_ctrl.sv
rtl/core/crrd_dp.sv
rtl/core/corner_region_red_dominance.sv
rtl/core/crrd_chk.sv
bench/tb_corner_region_red_dominance.sv
